// File: rtl/mfb_pkg.sv
// Shared types and constants for the max-flow search block.
`default_nettype none
package mfb_pkg;

  localparam int FLOW_W = 24;
  localparam int NODE_W = 3;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 24'hFFFFFF;

  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_SINK   = 1'b1;

  typedef enum logic [1:0] {
    ALU_MIN,
    ALU_SUB,
    ALU_ADD,
    ALU_SAT
  } alu_op_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_LOAD,
    S_BFS_INIT,
    S_POP,
    S_POP_W,
    S_RD,
    S_CHK,
    S_WALK_INIT,
    S_MN_P,
    S_MN_PW,
    S_MN_CHK,
    S_UP_INIT,
    S_UP_P,
    S_UP_PW,
    S_UP_FW,
    S_UP_BK,
    S_TOT,
    S_DONE
  } mfb_state_t;

endpackage
`default_nettype wire

// File: rtl/mfb_ram.sv
// Simple memory with one write port and one registered read port.
`default_nettype none
module mfb_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/mfb_alu.sv
// Shared arithmetic unit: minimum, subtract, add and saturating flow add.
`default_nettype none
module mfb_alu #(
  parameter int W = 25
) (
  input  wire mfb_pkg::alu_op_t op,
  input  wire logic [W-1:0]     a,
  input  wire logic [W-1:0]     b,
  output logic      [W-1:0]     y
);

  logic [W-1:0] sum;

  assign sum = a + b;

  always_comb begin
    case (op)
      mfb_pkg::ALU_MIN: y = (b < a) ? b : a;
      mfb_pkg::ALU_SUB: y = a - b;
      mfb_pkg::ALU_ADD: y = sum;
      mfb_pkg::ALU_SAT: y = (sum > W'(mfb_pkg::FLOW_MAX)) ? W'(mfb_pkg::FLOW_MAX) : sum;
      default:          y = sum;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/max_flow_bfs_augment_top.sv
// Top level of the max-flow block: matrix load, search sequencer and augmentation.
// Capacity entries load one beat per cycle into a residual memory of NODE_COUNT squared
// words (rounded up to a power of two per side). After the beat that carries last_entry,
// the block stalls its input and, if source and sink registers name distinct valid nodes,
// runs breadth-first searches from the source register; each examined edge takes one read
// of the residual memory and then one check. Each augmenting path then takes a minimum walk
// (parent read, residual read, minimum per hop) and a residual update (parent read, forward
// subtract, backward add per hop). Once no path remains and the last result has been taken,
// the total is placed in the output register and the residual memory is cleared one word per
// cycle; the same clearing pass runs after reset. Input is taken again once it finishes.
`default_nettype none
module max_flow_bfs_augment_top #(
  parameter int NODE_COUNT = 8,
  parameter int CAP_WIDTH  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_row_node,
  input  wire logic [2:0]  in_col_node,
  input  wire logic [15:0] in_edge_capacity,
  input  wire logic        in_last_entry,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_max_flow,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [2:0]  cfg_wdata
);

  localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int TW  = $clog2(NODE_COUNT + 1);
  localparam int SW  = CAP_WIDTH + 1;
  localparam int MAW = 2 * NW;
  localparam int AUW = ((SW > mfb_pkg::FLOW_W) ? SW : mfb_pkg::FLOW_W) + 1;
  localparam logic [SW-1:0] CAP_MASK = {1'b0, {CAP_WIDTH{1'b1}}};

  mfb_pkg::mfb_state_t state_r, state_nxt;

  logic [MAW-1:0] clr_r, clr_nxt;
  logic [TW-1:0]  head_r, head_nxt, tail_r, tail_nxt, guard_r, guard_nxt;
  logic [NW-1:0]  u_r, u_nxt, v_r, v_nxt, w_r, w_nxt, p_r, p_nxt;
  logic [NODE_COUNT-1:0] visited_r, visited_nxt;
  logic [SW-1:0]  amount_r, amount_nxt;
  logic [mfb_pkg::FLOW_W-1:0] total_r, total_nxt, out_flow_r, out_flow_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [2:0]     src_r, dst_r;

  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0]  mem_wdata, mem_rdata;
  logic           q_we;
  logic [NW-1:0]  q_waddr, q_wdata, q_rdata;
  logic           par_we;
  logic [NW-1:0]  par_rdata;

  mfb_pkg::alu_op_t alu_op;
  logic [AUW-1:0] alu_a, alu_b, alu_y;

  logic [NW-1:0]  src_idx, dst_idx, row_idx, col_idx;
  logic           ends_ok, entry_ok, in_acc, hit, walk_done;
  logic [SW-1:0]  cap_val;

  assign src_idx  = NW'(src_r);
  assign dst_idx  = NW'(dst_r);
  assign row_idx  = NW'(in_row_node);
  assign col_idx  = NW'(in_col_node);
  assign ends_ok  = (32'(src_r) < NODE_COUNT) && (32'(dst_r) < NODE_COUNT) && (src_r != dst_r);
  assign entry_ok = (32'(in_row_node) < NODE_COUNT) && (32'(in_col_node) < NODE_COUNT);
  assign in_acc   = in_valid && !in_stall;
  assign cap_val  = SW'(in_edge_capacity) & CAP_MASK;
  assign hit      = !visited_r[v_r] && (mem_rdata != '0);
  assign walk_done = (w_r == src_idx) || (guard_r == TW'(NODE_COUNT));

  mfb_ram #(.DW(SW), .AW(MAW)) u_resid (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  mfb_ram #(.DW(NW), .AW(NW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[NW-1:0]), .rdata(q_rdata)
  );

  mfb_ram #(.DW(NW), .AW(NW)) u_parent (
    .clk(clk), .we(par_we), .waddr(v_r), .wdata(u_r),
    .raddr(w_r), .rdata(par_rdata)
  );

  mfb_alu #(.W(AUW)) u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= 3'd0;
      dst_r <= 3'd7;
    end else if (cfg_wr_en) begin
      if (cfg_index == mfb_pkg::REG_SOURCE) begin
        src_r <= cfg_wdata;
      end else begin
        dst_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mfb_pkg::S_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    guard_r    <= guard_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    p_r        <= p_nxt;
    visited_r  <= visited_nxt;
    amount_r   <= amount_nxt;
    out_flow_r <= out_flow_nxt;
  end

  // Next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    guard_nxt     = guard_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    p_nxt         = p_r;
    visited_nxt   = visited_r;
    amount_nxt    = amount_r;
    total_nxt     = total_r;
    out_flow_nxt  = out_flow_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      mfb_pkg::S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = mfb_pkg::S_LOAD;
        end
      end
      mfb_pkg::S_LOAD: begin
        if (in_acc && in_last_entry) begin
          state_nxt = ends_ok ? mfb_pkg::S_BFS_INIT : mfb_pkg::S_DONE;
        end
      end
      mfb_pkg::S_BFS_INIT: begin
        visited_nxt          = '0;
        visited_nxt[src_idx] = 1'b1;
        head_nxt             = '0;
        tail_nxt             = TW'(1);
        state_nxt            = mfb_pkg::S_POP;
      end
      mfb_pkg::S_POP: begin
        state_nxt = (head_r == tail_r) ? mfb_pkg::S_DONE : mfb_pkg::S_POP_W;
      end
      mfb_pkg::S_POP_W: begin
        u_nxt     = q_rdata;
        head_nxt  = head_r + 1'b1;
        v_nxt     = '0;
        state_nxt = mfb_pkg::S_RD;
      end
      mfb_pkg::S_RD: begin
        state_nxt = mfb_pkg::S_CHK;
      end
      mfb_pkg::S_CHK: begin
        v_nxt     = v_r + 1'b1;
        state_nxt = (32'(v_r) == NODE_COUNT - 1) ? mfb_pkg::S_POP : mfb_pkg::S_RD;
        if (hit) begin
          visited_nxt[v_r] = 1'b1;
          if (v_r == dst_idx) begin
            state_nxt = mfb_pkg::S_WALK_INIT;
          end else if (tail_r < TW'(NODE_COUNT)) begin
            tail_nxt = tail_r + 1'b1;
          end
        end
      end
      mfb_pkg::S_WALK_INIT: begin
        amount_nxt = '1;
        w_nxt      = dst_idx;
        guard_nxt  = '0;
        state_nxt  = mfb_pkg::S_MN_P;
      end
      mfb_pkg::S_MN_P: begin
        state_nxt = walk_done ? mfb_pkg::S_UP_INIT : mfb_pkg::S_MN_PW;
      end
      mfb_pkg::S_MN_PW: begin
        p_nxt     = par_rdata;
        state_nxt = mfb_pkg::S_MN_CHK;
      end
      mfb_pkg::S_MN_CHK: begin
        amount_nxt = SW'(alu_y);
        w_nxt      = p_r;
        guard_nxt  = guard_r + 1'b1;
        state_nxt  = mfb_pkg::S_MN_P;
      end
      mfb_pkg::S_UP_INIT: begin
        w_nxt     = dst_idx;
        guard_nxt = '0;
        state_nxt = mfb_pkg::S_UP_P;
      end
      mfb_pkg::S_UP_P: begin
        state_nxt = walk_done ? mfb_pkg::S_TOT : mfb_pkg::S_UP_PW;
      end
      mfb_pkg::S_UP_PW: begin
        p_nxt     = par_rdata;
        state_nxt = mfb_pkg::S_UP_FW;
      end
      mfb_pkg::S_UP_FW: begin
        state_nxt = mfb_pkg::S_UP_BK;
      end
      mfb_pkg::S_UP_BK: begin
        w_nxt     = p_r;
        guard_nxt = guard_r + 1'b1;
        state_nxt = mfb_pkg::S_UP_P;
      end
      mfb_pkg::S_TOT: begin
        total_nxt = mfb_pkg::FLOW_W'(alu_y);
        state_nxt = mfb_pkg::S_BFS_INIT;
      end
      mfb_pkg::S_DONE: begin
        // Hold the total until the previous result beat has been taken.
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_flow_nxt  = total_r;
          total_nxt     = '0;
          clr_nxt       = '0;
          state_nxt     = mfb_pkg::S_CLEAR;
        end
      end
      default: state_nxt = mfb_pkg::S_CLEAR;
    endcase
  end

  // Memory ports, shared unit operands and handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = {u_r, v_r};
    q_we      = 1'b0;
    q_waddr   = tail_r[NW-1:0];
    q_wdata   = v_r;
    par_we    = 1'b0;
    alu_op    = mfb_pkg::ALU_MIN;
    alu_a     = AUW'(amount_r);
    alu_b     = AUW'(mem_rdata);
    case (state_r)
      mfb_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      mfb_pkg::S_LOAD: begin
        in_stall  = 1'b0;
        mem_we    = in_valid && entry_ok;
        mem_waddr = {row_idx, col_idx};
        mem_wdata = cap_val;
      end
      mfb_pkg::S_BFS_INIT: begin
        q_we    = 1'b1;
        q_waddr = '0;
        q_wdata = src_idx;
      end
      mfb_pkg::S_CHK: begin
        par_we = hit;
        q_we   = hit && (v_r != dst_idx) && (tail_r < TW'(NODE_COUNT));
      end
      mfb_pkg::S_MN_PW: begin
        mem_raddr = {par_rdata, w_r};
      end
      mfb_pkg::S_UP_PW: begin
        mem_raddr = {par_rdata, w_r};
      end
      mfb_pkg::S_UP_FW: begin
        alu_op    = mfb_pkg::ALU_SUB;
        alu_a     = AUW'(mem_rdata);
        alu_b     = AUW'(amount_r);
        mem_we    = 1'b1;
        mem_waddr = {p_r, w_r};
        mem_wdata = SW'(alu_y);
        mem_raddr = {w_r, p_r};
      end
      mfb_pkg::S_UP_BK: begin
        alu_op    = mfb_pkg::ALU_ADD;
        alu_a     = AUW'(mem_rdata);
        alu_b     = AUW'(amount_r);
        mem_we    = 1'b1;
        mem_waddr = {w_r, p_r};
        mem_wdata = SW'(alu_y);
      end
      mfb_pkg::S_TOT: begin
        alu_op = mfb_pkg::ALU_SAT;
        alu_a  = AUW'(total_r);
        alu_b  = AUW'(amount_r);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_max_flow = out_flow_r;

endmodule
`default_nettype wire

// File: rtl/mfb_checker.sv
// Port-level checks for the max-flow block and their binding.
`default_nettype none
module mfb_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_last_entry,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] out_max_flow
);

  // The beat that ends a matrix ends the load phase, so input must stall next.
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_entry) |=> in_stall)
    else $error("input not stalled after last entry");

  // A result only appears while the block is busy with its own work.
  a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_stall)
    else $error("result raised while loading");

  // Reset leaves no result pending and runs the clearing pass first.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("bad state after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_max_flow)))
    else $error("stalled result changed");

endmodule

bind max_flow_bfs_augment_top mfb_checker u_mfb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_last_entry(in_last_entry), .out_valid(out_valid), .out_stall(out_stall),
  .out_max_flow(out_max_flow)
);
`default_nettype wire
